FILE: hdl/lmlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlc_pkg
// Shared types and codes for the lift motor limit controller.
// ----------------------------------------------------------------------------
package lmlc_pkg;

   localparam logic [1:0] DRV_STOP = 2'd0;
   localparam logic [1:0] DRV_FWD  = 2'd1;
   localparam logic [1:0] DRV_REV  = 2'd2;

   localparam logic [2:0] ST_UNKNOWN   = 3'd0;
   localparam logic [2:0] ST_OPEN      = 3'd1;
   localparam logic [2:0] ST_CLOSED    = 3'd2;
   localparam logic [2:0] ST_UP        = 3'd3;
   localparam logic [2:0] ST_DOWN      = 3'd4;
   localparam logic [2:0] ST_STOPPED   = 3'd5;
   localparam logic [2:0] ST_EMERGENCY = 3'd6;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_UP   = 2'd2;
   localparam logic [1:0] CMD_DOWN = 2'd3;

   localparam logic [1:0] SRC_NONE   = 2'd0;
   localparam logic [1:0] SRC_BUTTON = 2'd1;
   localparam logic [1:0] SRC_REMOTE = 2'd2;

   localparam logic [1:0] REF_NONE        = 2'd0;
   localparam logic [1:0] REF_OVERCURRENT = 2'd1;
   localparam logic [1:0] REF_LIMIT       = 2'd2;

   localparam logic [1:0] CSR_CEILING_MOUNT = 2'd0;
   localparam logic [1:0] CSR_FWD_RUN_ON    = 2'd1;
   localparam logic [1:0] CSR_REV_RUN_ON    = 2'd2;

   typedef struct packed {
      logic       stop_button;
      logic       up_button;
      logic       down_button;
      logic [1:0] ir_command;
      logic       forward_limit;
      logic       reverse_limit;
      logic       overcurrent_trip;
      logic       driver_fault;
      logic [7:0] elapsed_ms;
   } req_data_type;

   typedef struct packed {
      logic [1:0] motor_drive;
      logic [2:0] lift_status;
      logic       overcurrent_latched;
      logic [1:0] refusal;
      logic [1:0] command_from;
   } rsp_data_type;

   typedef struct packed {
      logic        ceiling_mount;
      logic [15:0] forward_run_on_ms;
      logic [15:0] reverse_run_on_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  drive;
      logic [1:0]  run_dir;
      logic [15:0] run_elapsed;
      logic        oc_flag;
   } ctl_state_type;

endpackage

FILE: hdl/lmlc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlc_csr
// Configuration register file: mount orientation and run-on times.
// ----------------------------------------------------------------------------
module lmlc_csr import lmlc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CEILING_MOUNT: cfg_in.ceiling_mount     = csr_data[0];
            CSR_FWD_RUN_ON:    cfg_in.forward_run_on_ms = csr_data;
            CSR_REV_RUN_ON:    cfg_in.reverse_run_on_ms = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/lmlc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmlc_step
// Per-tick rule logic: fault, run-on, limit and command handling.
// ----------------------------------------------------------------------------
module lmlc_step import lmlc_pkg::*; (
   input  req_data_type  req,
   input  cfg_type       cfg,
   input  ctl_state_type cur,
   output ctl_state_type nxt,
   output rsp_data_type  rsp
);

   function automatic logic [2:0] limit_status(input logic [1:0] dir, input logic ceiling);
      logic fwd_side;
      begin
         fwd_side = (dir == DIR_FWD);
         limit_status = (fwd_side ^ ceiling) ? ST_OPEN : ST_CLOSED;
      end
   endfunction

   logic [16:0] sum;
   logic [15:0] sat;
   logic [15:0] run_limit;
   logic [1:0]  cmd;
   logic [1:0]  src;
   logic        cmd_lim;
   logic [1:0]  refusal;
   logic [1:0]  from;
   ctl_state_type s;

   assign sum       = {1'b0, cur.run_elapsed} + {9'd0, req.elapsed_ms};
   assign sat       = sum[16] ? 16'hFFFF : sum[15:0];
   assign run_limit = (cur.run_dir == DIR_FWD) ? cfg.forward_run_on_ms
                                               : cfg.reverse_run_on_ms;

   always_comb begin
      cmd = CMD_NONE;
      src = SRC_NONE;
      if (req.stop_button) begin
         cmd = CMD_STOP;
         src = SRC_BUTTON;
      end else if (req.up_button) begin
         cmd = CMD_UP;
         src = SRC_BUTTON;
      end else if (req.down_button) begin
         cmd = CMD_DOWN;
         src = SRC_BUTTON;
      end else if (req.ir_command != CMD_NONE) begin
         cmd = req.ir_command;
         src = SRC_REMOTE;
      end
      cmd_lim = (cmd == CMD_UP) ? req.forward_limit : req.reverse_limit;
   end

   always_comb begin
      s       = cur;
      refusal = REF_NONE;
      from    = SRC_NONE;
      if (req.overcurrent_trip) begin
         s.oc_flag = 1'b1;
         s.drive   = DRV_STOP;
      end
      if (req.driver_fault) begin
         s.run_dir = DIR_NONE;
         s.drive   = DRV_STOP;
         s.status  = ST_EMERGENCY;
      end else if (cur.run_dir != DIR_NONE) begin
         s.run_elapsed = sat;
         if (sat >= run_limit) begin
            s.drive   = DRV_STOP;
            s.run_dir = DIR_NONE;
            s.status  = limit_status((cur.run_dir == DIR_FWD) ? DIR_FWD : DIR_REV,
                                     cfg.ceiling_mount);
         end
      end else if (req.forward_limit && s.drive == DRV_FWD) begin
         if (cfg.forward_run_on_ms == 16'd0) begin
            s.drive  = DRV_STOP;
            s.status = limit_status(DIR_FWD, cfg.ceiling_mount);
         end else begin
            s.run_dir     = DIR_FWD;
            s.run_elapsed = 16'd0;
         end
      end else if (req.reverse_limit && s.drive == DRV_REV) begin
         if (cfg.reverse_run_on_ms == 16'd0) begin
            s.drive  = DRV_STOP;
            s.status = limit_status(DIR_REV, cfg.ceiling_mount);
         end else begin
            s.run_dir     = DIR_REV;
            s.run_elapsed = 16'd0;
         end
      end else begin
         case (cmd)
            CMD_STOP: begin
               s.oc_flag = 1'b0;
               s.run_dir = DIR_NONE;
               s.drive   = DRV_STOP;
               s.status  = ST_STOPPED;
               from      = src;
            end
            CMD_UP, CMD_DOWN: begin
               if (s.oc_flag) begin
                  refusal = REF_OVERCURRENT;
               end else if (cmd_lim) begin
                  refusal = REF_LIMIT;
               end else begin
                  s.drive  = (cmd == CMD_UP) ? DRV_FWD : DRV_REV;
                  s.status = (cmd == CMD_UP) ? ST_UP : ST_DOWN;
                  from     = src;
               end
            end
            default: begin
               from = SRC_NONE;
            end
         endcase
      end
   end

   assign nxt                     = s;
   assign rsp.motor_drive         = s.drive;
   assign rsp.lift_status         = s.status;
   assign rsp.overcurrent_latched = s.oc_flag;
   assign rsp.refusal             = refusal;
   assign rsp.command_from        = from;

endmodule

FILE: hdl/lift_motor_limit_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_motor_limit_controller_core
// Lift motor controller: one control tick in, one drive/status beat out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_valid/req_stall  req_data_type (one tick)
//  rsp_     out  rsp_valid/rsp_stall  rsp_data_type (drive and status)
//  csr_     in   csr_valid/csr_ready  csr_index, csr_data
//
//  A beat is registered on entry, evaluated against the controller state
//  and written to the result register when it is free: one beat per cycle
//  while rsp_stall is low. The state updates as a beat leaves the input
//  register, so the next beat sees it. Reset clears all state and
//  config. A stalled result holds; the input register then fills and stalls.
// ----------------------------------------------------------------------------
module lift_motor_limit_controller_core import lmlc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   cfg_type       cfg;
   logic          in_valid_ff;
   logic          in_valid_in;
   req_data_type  in_data_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_data_type  out_data_ff;
   ctl_state_type state_ff;
   ctl_state_type state_in;
   ctl_state_type step_state;
   rsp_data_type  step_rsp;
   logic          out_free;
   logic          fire;
   logic          take;

   lmlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lmlc_step u_step (
      .req (in_data_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (step_state),
      .rsp (step_rsp)
   );

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign fire         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign take         = req_valid && !req_stall;
   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);
   assign state_in     = fire ? step_state : state_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule
